### rtl/assert_macros.svh
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define TKN_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define TKN_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define TKN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tkn_pkg.sv
// Types and constants of the top-k neighbor keeper.
`default_nettype none

package tkn_pkg;

   localparam int MAX_K         = 32;
   localparam int SLOT_BITS     = $clog2(MAX_K);
   localparam int FILL_BITS     = $clog2(MAX_K + 1);
   localparam int K_BITS        = 6;
   localparam int CNT_BITS      = (K_BITS > FILL_BITS) ? K_BITS : FILL_BITS;
   localparam int ID_BITS       = 32;
   localparam int DIST_BITS     = 32;
   localparam int RANK_BITS     = 5;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = K_BITS;

   localparam logic [CSR_IDX_BITS-1:0] REG_K_IN_USE    = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_METRIC_MODE = CSR_IDX_BITS'(1);

   localparam logic [K_BITS-1:0] K_RESET = K_BITS'(10);

   typedef logic [SLOT_BITS-1:0]        slot_type;
   typedef logic [FILL_BITS-1:0]        fill_type;
   typedef logic [K_BITS-1:0]           k_type;
   typedef logic [CNT_BITS-1:0]         cnt_type;
   typedef logic [ID_BITS-1:0]          id_type;
   typedef logic signed [DIST_BITS-1:0] dist_type;
   typedef logic [RANK_BITS-1:0]        rank_type;

   typedef struct packed {
      id_type   cand_id;
      dist_type cand_distance;
      logic     cand_missing;
      logic     query_end;
   } req_type;

   typedef struct packed {
      id_type   neighbor_id;
      dist_type neighbor_distance;
      rank_type rank;
      logic     found;
      logic     list_last;
   } rsp_type;

   // one slot of the kept list
   typedef struct packed {
      id_type   id;
      dist_type distance;
   } entry_type;

endpackage

`default_nettype wire

### rtl/tkn_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tkn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/top_k_neighbor_keeper_top.sv
// Top level: keeps the k best candidates in a slot RAM and emits them sorted.
// Append of a candidate while fewer than k are held: written when accepted, next request the cycle after.
// Replacing when full: one RAM read per held slot to find the worst, then a decide state.
// Query end with n held: n passes, each reading every held slot, one result strobe per pass;
//   the slot RAM read port reads one slot per cycle. Results cannot stall.
// Reset (synchronous, active high) empties the list, sets k to 10 and L2 mode;
//   the slot RAM is not cleared, since only filled slots are ever read.
`default_nettype none
`include "assert_macros.svh"

module top_k_neighbor_keeper_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire tkn_pkg::req_type                    req_item,
   input  wire logic                                csr_we,
   input  wire logic [tkn_pkg::CSR_IDX_BITS-1:0]    csr_idx,
   input  wire logic [tkn_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                     rsp_valid,
   output tkn_pkg::rsp_type                         rsp_item
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WSCAN = 3'd1;
   localparam logic [2:0] S_WDEC  = 3'd2;
   localparam logic [2:0] S_SORT  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   function automatic logic better(input logic mode, input tkn_pkg::dist_type a,
                                   input tkn_pkg::dist_type b);
      return mode ? (a > b) : (a < b);
   endfunction

   function automatic logic ranks_before(input logic mode,
                                         input tkn_pkg::entry_type a,
                                         input tkn_pkg::entry_type b);
      logic a_better;
      logic same;
      a_better = better(mode, a.distance, b.distance);
      same     = (a.distance == b.distance);
      return a_better || (same && (a.id < b.id));
   endfunction

   function automatic tkn_pkg::cnt_type eff_k(input tkn_pkg::k_type k);
      tkn_pkg::cnt_type kc;
      kc = tkn_pkg::cnt_type'(k);
      if (kc == '0) begin
         return tkn_pkg::cnt_type'(1);
      end
      if (kc > tkn_pkg::cnt_type'(tkn_pkg::MAX_K)) begin
         return tkn_pkg::cnt_type'(tkn_pkg::MAX_K);
      end
      return kc;
   endfunction

   logic [2:0]              state_ff, state_in;
   tkn_pkg::k_type          k_ff;
   logic                    mode_ff;
   tkn_pkg::fill_type       fill_ff, fill_in;
   tkn_pkg::entry_type      cand_ff, cand_in;
   logic                    last_ff, last_in;
   tkn_pkg::fill_type       scan_ff, scan_in;
   logic                    rv_ff, rv_in;
   tkn_pkg::slot_type       ridx_ff, ridx_in;
   tkn_pkg::dist_type       worst_ff, worst_in;
   tkn_pkg::slot_type       worst_idx_ff, worst_idx_in;
   tkn_pkg::entry_type      best_ff, best_in;
   tkn_pkg::slot_type       best_idx_ff, best_idx_in;
   logic                    have_ff, have_in;
   logic [tkn_pkg::MAX_K-1:0] used_ff, used_in;
   tkn_pkg::slot_type       rank_ff, rank_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tkn_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    wr_en;
   tkn_pkg::slot_type       wr_addr;
   tkn_pkg::entry_type      wr_data;
   logic                    rd_en;
   tkn_pkg::entry_type      rd_data;

   logic                    accept;
   logic                    append_ok;
   logic                    scan_done;
   logic                    list_end;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign append_ok = tkn_pkg::cnt_type'(fill_ff) < eff_k(k_ff);
   assign rd_en     = ((state_ff == S_WSCAN) || (state_ff == S_SORT)) && (scan_ff < fill_ff);
   assign scan_done = rv_ff && ((tkn_pkg::fill_type'(ridx_ff) + tkn_pkg::fill_type'(1))
                                == fill_ff);
   assign list_end  = (fill_ff == '0) ||
                      ((tkn_pkg::fill_type'(rank_ff) + tkn_pkg::fill_type'(1)) == fill_ff);

   tkn_ram #(
      .WIDTH ($bits(tkn_pkg::entry_type)),
      .DEPTH (tkn_pkg::MAX_K)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[tkn_pkg::SLOT_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cand_in      = cand_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      rv_in        = rd_en;
      ridx_in      = scan_ff[tkn_pkg::SLOT_BITS-1:0];
      worst_in     = worst_ff;
      worst_idx_in = worst_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      have_in      = 1'b0;
      used_in      = used_ff;
      rank_in      = rank_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[tkn_pkg::SLOT_BITS-1:0];
      wr_data      = cand_ff;

      if (rd_en) begin
         scan_in = scan_ff + tkn_pkg::fill_type'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cand_in = '{id: req_item.cand_id, distance: req_item.cand_distance};
               last_in = req_item.query_end;
               scan_in = '0;
               if (!req_item.cand_missing && append_ok) begin
                  wr_en   = 1'b1;
                  wr_data = cand_in;
                  fill_in = fill_ff + tkn_pkg::fill_type'(1);
               end
               if (!req_item.cand_missing && !append_ok) begin
                  state_in = S_WSCAN;
               end else if (req_item.query_end) begin
                  state_in = (fill_in == '0) ? S_EMIT : S_SORT;
               end
            end
         end
         S_WSCAN: begin
            // worst entry, lowest slot among equal worsts
            if (rv_ff && ((ridx_ff == '0) || better(mode_ff, worst_ff, rd_data.distance))) begin
               worst_in     = rd_data.distance;
               worst_idx_in = ridx_ff;
            end
            if (scan_done) begin
               state_in = S_WDEC;
            end
         end
         S_WDEC: begin
            if (better(mode_ff, cand_ff.distance, worst_ff)) begin
               wr_en   = 1'b1;
               wr_addr = worst_idx_ff;
               wr_data = cand_ff;
            end
            scan_in  = '0;
            state_in = last_ff ? S_SORT : S_IDLE;
         end
         S_SORT: begin
            // one selection pass: best not yet emitted, earliest slot wins full ties
            have_in = have_ff;
            if (rv_ff && !used_ff[ridx_ff] &&
                (!have_ff || ranks_before(mode_ff, rd_data, best_ff))) begin
               best_in     = rd_data;
               best_idx_in = ridx_ff;
               have_in     = 1'b1;
            end
            if (scan_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.found             = (fill_ff != '0);
            rsp_in.neighbor_id       = (fill_ff != '0) ? best_ff.id : '0;
            rsp_in.neighbor_distance = (fill_ff != '0) ? best_ff.distance : '0;
            rsp_in.rank              = tkn_pkg::rank_type'(rank_ff);
            rsp_in.list_last         = list_end;
            scan_in = '0;
            if (list_end) begin
               fill_in  = '0;
               used_in  = '0;
               rank_in  = '0;
               state_in = S_IDLE;
            end else begin
               used_in[best_idx_ff] = 1'b1;
               rank_in  = rank_ff + tkn_pkg::slot_type'(1);
               state_in = S_SORT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rv_ff        <= 1'b0;
         have_ff      <= 1'b0;
         used_ff      <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         rv_ff        <= rv_in;
         have_ff      <= have_in;
         used_ff      <= used_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      last_ff      <= last_in;
      ridx_ff      <= ridx_in;
      worst_ff     <= worst_in;
      worst_idx_ff <= worst_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= tkn_pkg::K_RESET;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx)
            tkn_pkg::REG_K_IN_USE:    k_ff    <= csr_wdata[tkn_pkg::K_BITS-1:0];
            tkn_pkg::REG_METRIC_MODE: mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `TKN_ASSERT_HOLDS(a_fill_max, clock, reset, fill_ff <= tkn_pkg::fill_type'(tkn_pkg::MAX_K), "fill count above MAX_K")
   `TKN_ASSERT_IMPL(a_empty_rsp, clock, reset, rsp_valid_ff && !rsp_ff.found, rsp_ff.list_last && (rsp_ff.rank == '0), "empty list result malformed")
   `TKN_ASSERT_IMPL(a_last_clears, clock, reset, rsp_valid_ff && rsp_ff.list_last, fill_ff == '0, "list not emptied after last result")
   `TKN_ASSERT_IMPL(a_used_rank, clock, reset, state_ff == S_SORT, $countones(used_ff) == int'(rank_ff), "emitted marks out of step with rank")
   `TKN_ASSERT_NEXT(a_full_scan, clock, reset, accept && !req_item.cand_missing && !append_ok, state_ff == S_WSCAN, "full list did not start worst search")

endmodule

`default_nettype wire
